@@ src/ecpad_pkg.sv @@
// Shared types, constants and field arithmetic for the elliptic-curve point unit.
package ecpad_pkg;

    localparam int FIELD_BITS = 32;
    localparam int CNT_BITS   = $clog2(FIELD_BITS);

    localparam logic [FIELD_BITS-1:0] FIELD_ONE = {{(FIELD_BITS-1){1'b0}}, 1'b1};

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DOUBLE = 2'd1;
    localparam logic [1:0] CMD_SUB    = 2'd2;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_CURVE_A = 1'b1;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [FIELD_BITS-1:0] first_x;
        logic [FIELD_BITS-1:0] first_y;
        logic [FIELD_BITS-1:0] second_x;
        logic [FIELD_BITS-1:0] second_y;
    } request_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] result_x;
        logic [FIELD_BITS-1:0] result_y;
        logic                  degenerate;
    } result_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_RED_X1,
        OP_RED_Y1,
        OP_RED_X2,
        OP_RED_Y2,
        OP_RED_A,
        OP_DEG_ZERO,
        OP_DBL_PREP,
        OP_DBL_N1,
        OP_DBL_N2,
        OP_DBL_N3,
        OP_NEG_Y2,
        OP_ADD_PREP,
        OP_INV_INIT,
        OP_EUC_DIV,
        OP_EUC_MUL,
        OP_EUC_UPD,
        OP_SLOPE,
        OP_SQR,
        OP_X3,
        OP_DIFF,
        OP_YMUL,
        OP_Y3,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        DD_X1,
        DD_Y1,
        DD_X2,
        DD_Y2,
        DD_A,
        DD_EUC
    } div_dst_t;

    typedef enum logic [1:0] {
        MD_NUM,
        MD_PROD,
        MD_SLOPE
    } mul_dst_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RED_X1,
        ST_W_X1,
        ST_RED_Y1,
        ST_W_Y1,
        ST_RED_X2,
        ST_W_X2,
        ST_RED_Y2,
        ST_W_Y2,
        ST_RED_A,
        ST_W_A,
        ST_BRANCH,
        ST_DEG_ZERO,
        ST_DBL_MUL,
        ST_W_DBL,
        ST_DBL_N1,
        ST_DBL_N2,
        ST_DBL_N3,
        ST_NEG_Y2,
        ST_ADD_PREP,
        ST_INV_INIT,
        ST_EUC_TEST,
        ST_EUC_DIV,
        ST_W_DIV,
        ST_EUC_MUL,
        ST_W_MUL,
        ST_EUC_UPD,
        ST_SLOPE,
        ST_W_SLOPE,
        ST_SQR,
        ST_W_SQR,
        ST_X3,
        ST_DIFF,
        ST_YMUL,
        ST_W_YMUL,
        ST_Y3,
        ST_DONE
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       div_busy;
        logic       mul_busy;
        logic       m_zero;
        logic       y1_zero;
        logic       g1_zero;
        logic [1:0] cmd;
    } dp_status_t;

    function automatic logic [FIELD_BITS-1:0] fadd(input logic [FIELD_BITS-1:0] a,
                                                   input logic [FIELD_BITS-1:0] b,
                                                   input logic [FIELD_BITS-1:0] m);
        logic [FIELD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[FIELD_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] fsub(input logic [FIELD_BITS-1:0] a,
                                                   input logic [FIELD_BITS-1:0] b,
                                                   input logic [FIELD_BITS-1:0] m);
        logic [FIELD_BITS:0] d;
        if (a >= b)
        begin
            d = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            d = {1'b0, a} + ({1'b0, m} - {1'b0, b});
        end
        return d[FIELD_BITS-1:0];
    endfunction

endpackage

@@ src/ecpad_div.sv @@
// Restoring divider, one quotient bit per cycle.
module ecpad_div
    import ecpad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FIELD_BITS-1:0] dividend,
    input  logic [FIELD_BITS-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [FIELD_BITS-1:0] quotient,
    output logic [FIELD_BITS-1:0] remainder
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [FIELD_BITS-1:0] num_reg, num_next;
    logic [FIELD_BITS-1:0] den_reg, den_next;
    logic [FIELD_BITS-1:0] quo_reg, quo_next;
    logic [FIELD_BITS-1:0] rem_reg, rem_next;
    logic [FIELD_BITS:0]   trial;
    logic [FIELD_BITS:0]   diff;
    logic                  ge;

    always_comb
    begin
        trial = {rem_reg, num_reg[FIELD_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(FIELD_BITS - 1);
            num_next  = dividend;
            den_next  = divisor;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[FIELD_BITS-1:0] : trial[FIELD_BITS-1:0];
            quo_next = {quo_reg[FIELD_BITS-2:0], ge};
            num_next = {num_reg[FIELD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ src/ecpad_mul.sv @@
// Interleaved modular multiplier, one multiplier bit per cycle.
module ecpad_mul
    import ecpad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FIELD_BITS-1:0] op_a,
    input  logic [FIELD_BITS-1:0] op_b,
    input  logic [FIELD_BITS-1:0] modulus,
    output logic                  busy,
    output logic                  done,
    output logic [FIELD_BITS-1:0] product
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [FIELD_BITS-1:0] a_reg, a_next;
    logic [FIELD_BITS-1:0] b_reg, b_next;
    logic [FIELD_BITS-1:0] m_reg, m_next;
    logic [FIELD_BITS-1:0] acc_reg, acc_next;
    logic [FIELD_BITS-1:0] dbl;

    always_comb
    begin
        dbl = fadd(acc_reg, acc_reg, m_reg);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(FIELD_BITS - 1);
            a_next    = op_a;
            b_next    = op_b;
            m_next    = modulus;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = b_reg[FIELD_BITS-1] ? fadd(dbl, a_reg, m_reg) : dbl;
            b_next   = {b_reg[FIELD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ src/ecpad_datapath.sv @@
// Datapath: configuration, working registers, shared divider and multiplier, result register.
module ecpad_datapath
    import ecpad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [FIELD_BITS-1:0] cfg_data,
    input  request_t              req_data,
    input  dp_cmd_t               dp_cmd,
    output dp_status_t            dp_status,
    output result_t               res_data
);

    logic [FIELD_BITS-1:0] mod_reg, mod_next;
    logic [FIELD_BITS-1:0] ca_cfg_reg, ca_cfg_next;

    logic [1:0]            cmd_reg, cmd_next;
    logic [FIELD_BITS-1:0] x1_reg, x1_next;
    logic [FIELD_BITS-1:0] y1_reg, y1_next;
    logic [FIELD_BITS-1:0] x2_reg, x2_next;
    logic [FIELD_BITS-1:0] y2_reg, y2_next;
    logic [FIELD_BITS-1:0] ca_reg, ca_next;
    logic [FIELD_BITS-1:0] num_reg, num_next;
    logic [FIELD_BITS-1:0] den_reg, den_next;
    logic [FIELD_BITS-1:0] xsum_reg, xsum_next;
    logic [FIELD_BITS-1:0] tmp_reg, tmp_next;
    logic [FIELD_BITS-1:0] u_reg, u_next;
    logic [FIELD_BITS-1:0] u1_reg, u1_next;
    logic [FIELD_BITS-1:0] g_reg, g_next;
    logic [FIELD_BITS-1:0] g1_reg, g1_next;
    logic [FIELD_BITS-1:0] s_reg, s_next;
    logic [FIELD_BITS-1:0] prod_reg, prod_next;
    logic [FIELD_BITS-1:0] rx_reg, rx_next;
    logic [FIELD_BITS-1:0] ry_reg, ry_next;
    logic                  deg_reg, deg_next;
    result_t               out_reg, out_next;
    div_dst_t              div_dst_reg, div_dst_next;
    mul_dst_t              mul_dst_reg, mul_dst_next;

    logic                  div_start, div_busy, div_done;
    logic [FIELD_BITS-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic                  mul_start, mul_busy, mul_done;
    logic [FIELD_BITS-1:0] mul_a, mul_b, mul_prod;
    logic [FIELD_BITS-1:0] q_mod;

    ecpad_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    ecpad_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mod_reg),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign q_mod = (div_quo == mod_reg) ? '0 : div_quo;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = x1_reg;
        div_divisor  = mod_reg;
        div_dst_next = div_dst_reg;
        mul_start    = 1'b0;
        mul_a        = x1_reg;
        mul_b        = x1_reg;
        mul_dst_next = mul_dst_reg;

        unique case (dp_cmd.op)
            OP_RED_X1:
            begin
                div_start    = 1'b1;
                div_dividend = x1_reg;
                div_dst_next = DD_X1;
            end
            OP_RED_Y1:
            begin
                div_start    = 1'b1;
                div_dividend = y1_reg;
                div_dst_next = DD_Y1;
            end
            OP_RED_X2:
            begin
                div_start    = 1'b1;
                div_dividend = x2_reg;
                div_dst_next = DD_X2;
            end
            OP_RED_Y2:
            begin
                div_start    = 1'b1;
                div_dividend = y2_reg;
                div_dst_next = DD_Y2;
            end
            OP_RED_A:
            begin
                div_start    = 1'b1;
                div_dividend = ca_cfg_reg;
                div_dst_next = DD_A;
            end
            OP_EUC_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = g_reg;
                div_divisor  = g1_reg;
                div_dst_next = DD_EUC;
            end
            OP_DBL_PREP:
            begin
                mul_start    = 1'b1;
                mul_a        = x1_reg;
                mul_b        = x1_reg;
                mul_dst_next = MD_NUM;
            end
            OP_EUC_MUL:
            begin
                mul_start    = 1'b1;
                mul_a        = q_mod;
                mul_b        = u1_reg;
                mul_dst_next = MD_PROD;
            end
            OP_SLOPE:
            begin
                mul_start    = 1'b1;
                mul_a        = num_reg;
                mul_b        = u_reg;
                mul_dst_next = MD_SLOPE;
            end
            OP_SQR:
            begin
                mul_start    = 1'b1;
                mul_a        = s_reg;
                mul_b        = s_reg;
                mul_dst_next = MD_PROD;
            end
            OP_YMUL:
            begin
                mul_start    = 1'b1;
                mul_a        = s_reg;
                mul_b        = tmp_reg;
                mul_dst_next = MD_PROD;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        mod_next    = mod_reg;
        ca_cfg_next = ca_cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODULUS: mod_next    = cfg_data;
                CFG_CURVE_A: ca_cfg_next = cfg_data;
                default:     mod_next    = mod_reg;
            endcase
        end
    end

    always_comb
    begin
        cmd_next  = cmd_reg;
        x1_next   = x1_reg;
        y1_next   = y1_reg;
        x2_next   = x2_reg;
        y2_next   = y2_reg;
        ca_next   = ca_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        xsum_next = xsum_reg;
        tmp_next  = tmp_reg;
        u_next    = u_reg;
        u1_next   = u1_reg;
        g_next    = g_reg;
        g1_next   = g1_reg;
        s_next    = s_reg;
        prod_next = prod_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        deg_next  = deg_reg;
        out_next  = out_reg;

        unique case (dp_cmd.op)
            OP_LOAD:
            begin
                cmd_next = req_data.cmd;
                x1_next  = req_data.first_x;
                y1_next  = req_data.first_y;
                x2_next  = req_data.second_x;
                y2_next  = req_data.second_y;
                rx_next  = '0;
                ry_next  = '0;
                deg_next = 1'b0;
            end
            OP_DEG_ZERO:
            begin
                deg_next = 1'b1;
            end
            OP_DBL_PREP:
            begin
                den_next  = fadd(y1_reg, y1_reg, mod_reg);
                xsum_next = fadd(x1_reg, x1_reg, mod_reg);
            end
            OP_DBL_N1:
            begin
                tmp_next = fadd(num_reg, num_reg, mod_reg);
            end
            OP_DBL_N2:
            begin
                tmp_next = fadd(tmp_reg, num_reg, mod_reg);
            end
            OP_DBL_N3:
            begin
                num_next = fadd(tmp_reg, ca_reg, mod_reg);
            end
            OP_NEG_Y2:
            begin
                y2_next = fsub('0, y2_reg, mod_reg);
            end
            OP_ADD_PREP:
            begin
                den_next  = fsub(x2_reg, x1_reg, mod_reg);
                num_next  = fsub(y2_reg, y1_reg, mod_reg);
                xsum_next = fadd(x1_reg, x2_reg, mod_reg);
            end
            OP_INV_INIT:
            begin
                u_next   = (mod_reg == FIELD_ONE) ? '0 : FIELD_ONE;
                u1_next  = '0;
                g_next   = den_reg;
                g1_next  = mod_reg;
                deg_next = (den_reg == '0);
            end
            OP_EUC_UPD:
            begin
                u_next  = u1_reg;
                u1_next = fsub(u_reg, prod_reg, mod_reg);
                g_next  = g1_reg;
                g1_next = div_rem;
            end
            OP_X3:
            begin
                rx_next = fsub(prod_reg, xsum_reg, mod_reg);
            end
            OP_DIFF:
            begin
                tmp_next = fsub(x1_reg, rx_reg, mod_reg);
            end
            OP_Y3:
            begin
                ry_next = fsub(prod_reg, y1_reg, mod_reg);
            end
            OP_EMIT:
            begin
                out_next.result_x   = rx_reg;
                out_next.result_y   = ry_reg;
                out_next.degenerate = deg_reg;
            end
            default:
            begin
            end
        endcase

        if (div_done)
        begin
            unique case (div_dst_reg)
                DD_X1:   x1_next = div_rem;
                DD_Y1:   y1_next = div_rem;
                DD_X2:   x2_next = div_rem;
                DD_Y2:   y2_next = div_rem;
                DD_A:    ca_next = div_rem;
                default: ca_next = ca_reg;
            endcase
        end

        if (mul_done)
        begin
            unique case (mul_dst_reg)
                MD_NUM:   num_next  = mul_prod;
                MD_PROD:  prod_next = mul_prod;
                MD_SLOPE: s_next    = mul_prod;
                default:  s_next    = s_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg    <= FIELD_BITS'(23);
            ca_cfg_reg <= FIELD_ONE;
        end
        else
        begin
            mod_reg    <= mod_next;
            ca_cfg_reg <= ca_cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        x2_reg      <= x2_next;
        y2_reg      <= y2_next;
        ca_reg      <= ca_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        xsum_reg    <= xsum_next;
        tmp_reg     <= tmp_next;
        u_reg       <= u_next;
        u1_reg      <= u1_next;
        g_reg       <= g_next;
        g1_reg      <= g1_next;
        s_reg       <= s_next;
        prod_reg    <= prod_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        deg_reg     <= deg_next;
        out_reg     <= out_next;
        div_dst_reg <= div_dst_next;
        mul_dst_reg <= mul_dst_next;
    end

    assign dp_status.div_busy = div_busy;
    assign dp_status.mul_busy = mul_busy;
    assign dp_status.m_zero   = (mod_reg == '0);
    assign dp_status.y1_zero  = (y1_reg == '0);
    assign dp_status.g1_zero  = (g1_reg == '0);
    assign dp_status.cmd      = cmd_reg;
    assign res_data           = out_reg;

endmodule

@@ src/ecpad_ctrl.sv @@
// Controller: sequences reductions, slope, Euclid inverse and point formulas; drives the handshakes.
module ecpad_ctrl
    import ecpad_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       res_valid,
    input  logic       res_stall,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   slot_free;

    assign slot_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = dp_status.m_zero ? ST_DONE : ST_RED_X1;
                end
            end
            ST_RED_X1:   state_next = ST_W_X1;
            ST_W_X1:     state_next = dp_status.div_busy ? ST_W_X1 : ST_RED_Y1;
            ST_RED_Y1:   state_next = ST_W_Y1;
            ST_W_Y1:     state_next = dp_status.div_busy ? ST_W_Y1 : ST_RED_X2;
            ST_RED_X2:   state_next = ST_W_X2;
            ST_W_X2:     state_next = dp_status.div_busy ? ST_W_X2 : ST_RED_Y2;
            ST_RED_Y2:   state_next = ST_W_Y2;
            ST_W_Y2:     state_next = dp_status.div_busy ? ST_W_Y2 : ST_RED_A;
            ST_RED_A:    state_next = ST_W_A;
            ST_W_A:      state_next = dp_status.div_busy ? ST_W_A : ST_BRANCH;
            ST_BRANCH:
            begin
                priority if (dp_status.cmd == CMD_DOUBLE)
                begin
                    state_next = dp_status.y1_zero ? ST_DEG_ZERO : ST_DBL_MUL;
                end
                else if (dp_status.cmd == CMD_SUB)
                begin
                    state_next = ST_NEG_Y2;
                end
                else
                begin
                    state_next = ST_ADD_PREP;
                end
            end
            ST_DEG_ZERO: state_next = ST_DONE;
            ST_DBL_MUL:  state_next = ST_W_DBL;
            ST_W_DBL:    state_next = dp_status.mul_busy ? ST_W_DBL : ST_DBL_N1;
            ST_DBL_N1:   state_next = ST_DBL_N2;
            ST_DBL_N2:   state_next = ST_DBL_N3;
            ST_DBL_N3:   state_next = ST_INV_INIT;
            ST_NEG_Y2:   state_next = ST_ADD_PREP;
            ST_ADD_PREP: state_next = ST_INV_INIT;
            ST_INV_INIT: state_next = ST_EUC_TEST;
            ST_EUC_TEST: state_next = dp_status.g1_zero ? ST_SLOPE : ST_EUC_DIV;
            ST_EUC_DIV:  state_next = ST_W_DIV;
            ST_W_DIV:    state_next = dp_status.div_busy ? ST_W_DIV : ST_EUC_MUL;
            ST_EUC_MUL:  state_next = ST_W_MUL;
            ST_W_MUL:    state_next = dp_status.mul_busy ? ST_W_MUL : ST_EUC_UPD;
            ST_EUC_UPD:  state_next = ST_EUC_TEST;
            ST_SLOPE:    state_next = ST_W_SLOPE;
            ST_W_SLOPE:  state_next = dp_status.mul_busy ? ST_W_SLOPE : ST_SQR;
            ST_SQR:      state_next = ST_W_SQR;
            ST_W_SQR:    state_next = dp_status.mul_busy ? ST_W_SQR : ST_X3;
            ST_X3:       state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_YMUL;
            ST_YMUL:     state_next = ST_W_YMUL;
            ST_W_YMUL:   state_next = dp_status.mul_busy ? ST_W_YMUL : ST_Y3;
            ST_Y3:       state_next = ST_DONE;
            ST_DONE:     state_next = slot_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        dp_cmd.op = OP_NOP;
        unique case (state_reg)
            ST_IDLE:     dp_cmd.op = req_valid ? OP_LOAD : OP_NOP;
            ST_RED_X1:   dp_cmd.op = OP_RED_X1;
            ST_RED_Y1:   dp_cmd.op = OP_RED_Y1;
            ST_RED_X2:   dp_cmd.op = OP_RED_X2;
            ST_RED_Y2:   dp_cmd.op = OP_RED_Y2;
            ST_RED_A:    dp_cmd.op = OP_RED_A;
            ST_DEG_ZERO: dp_cmd.op = OP_DEG_ZERO;
            ST_DBL_MUL:  dp_cmd.op = OP_DBL_PREP;
            ST_DBL_N1:   dp_cmd.op = OP_DBL_N1;
            ST_DBL_N2:   dp_cmd.op = OP_DBL_N2;
            ST_DBL_N3:   dp_cmd.op = OP_DBL_N3;
            ST_NEG_Y2:   dp_cmd.op = OP_NEG_Y2;
            ST_ADD_PREP: dp_cmd.op = OP_ADD_PREP;
            ST_INV_INIT: dp_cmd.op = OP_INV_INIT;
            ST_EUC_DIV:  dp_cmd.op = OP_EUC_DIV;
            ST_EUC_MUL:  dp_cmd.op = OP_EUC_MUL;
            ST_EUC_UPD:  dp_cmd.op = OP_EUC_UPD;
            ST_SLOPE:    dp_cmd.op = OP_SLOPE;
            ST_SQR:      dp_cmd.op = OP_SQR;
            ST_X3:       dp_cmd.op = OP_X3;
            ST_DIFF:     dp_cmd.op = OP_DIFF;
            ST_YMUL:     dp_cmd.op = OP_YMUL;
            ST_Y3:       dp_cmd.op = OP_Y3;
            ST_DONE:     dp_cmd.op = slot_free ? OP_EMIT : OP_NOP;
            default:     dp_cmd.op = OP_NOP;
        endcase
    end

    always_comb
    begin
        if ((state_reg == ST_DONE) && slot_free)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;

endmodule

@@ src/ec_point_add_double_unit_top.sv @@
// Top level of the affine elliptic-curve point add, double and subtract unit.
//
// Request channel (req_valid, req_stall, req_data): a request carries a command
// (add, double, subtract) and two affine points; it is taken when req_valid is
// high and req_stall low. Result channel (res_valid, res_stall, res_data): the
// resulting point and a degenerate flag, held unchanged while res_stall is high.
// Configuration (cfg_we, cfg_index, cfg_data): index 0 is the field modulus,
// index 1 the curve coefficient a; write only while the unit is idle.
// One request is worked on at a time. A subtract negates the second y, then runs
// as an add; a double first forms 3x^2 + a. The slope inverse runs extended
// Euclid steps until the remainder is zero. A zero modulus goes straight to the
// result; a double with y zero skips the slope. Reductions, Euclid quotients and
// products use the shared one-bit-a-cycle divider and multiplier.
// A finished result waits in the output register while the next request is
// taken and worked on; a stalled result only holds the unit once that next
// result is ready too. Reset clears the controller, drops any pending result
// and restores modulus 23 and a = 1.
module ec_point_add_double_unit_top
    import ecpad_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  request_t              req_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output result_t               res_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [FIELD_BITS-1:0] cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    ecpad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    ecpad_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .res_data  (res_data)
    );

endmodule
